FILE: design/ptrdr_pkg.sv
// shared types and constants for the pulse-timing random bit source
// used by ptrdr_ctrl, ptrdr_dp and pulse_timing_rng_dice_roller_core; no dependencies
`default_nettype none

package ptrdr_pkg;

    // request codes
    localparam logic [1:0] REQ_PULSE = 2'd0;
    localparam logic [1:0] REQ_BYTE  = 2'd1;
    localparam logic [1:0] REQ_ROLL  = 2'd2;
    localparam logic [1:0] REQ_NONE  = 2'd3;

    // result status codes
    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_EMPTY = 1'b1;

    // dice range limits and reset value
    localparam logic [7:0] DICE_MIN   = 8'd2;
    localparam logic [7:0] DICE_MAX   = 8'd128;
    localparam logic [7:0] DICE_RESET = 8'd2;

    localparam int BYTE_BITS = 8;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] pulse_time;
    } item_t;

    typedef struct packed {
        logic [7:0] value;
        logic       status;
        logic [6:0] bits_available;
    } result_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic pulse_a;
        logic pulse_b;
        logic pop_byte;
        logic set_ok;
        logic roll_step;
        logic finish;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic phase_end;
        logic empty;
        logic ge8;
        logic roll_hit;
    } stat_t;

endpackage

`default_nettype wire

FILE: design/ptrdr_ctrl.sv
// sequencing controller for the pulse-timing random bit source
// depends on ptrdr_pkg; drives ptrdr_dp through cmd_t and reads stat_t
`default_nettype none

module ptrdr_ctrl
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [1:0]        req_type,
    input  wire ptrdr_pkg::stat_t  stat,
    output ptrdr_pkg::cmd_t        cmd,
    output logic                   busy,
    output logic                   cfg_ready
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PULSE_A,
        S_PULSE_B,
        S_BYTE_CHK,
        S_BYTE_POP,
        S_ROLL,
        S_FIN
    } state_t;

    state_t     state_reg, state_next;
    logic [2:0] cnt_reg, cnt_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    unique case (req_type)
                        ptrdr_pkg::REQ_PULSE: state_next = S_PULSE_A;
                        ptrdr_pkg::REQ_BYTE:  state_next = S_BYTE_CHK;
                        ptrdr_pkg::REQ_ROLL:  state_next = S_ROLL;
                        ptrdr_pkg::REQ_NONE:  state_next = S_IDLE;
                        default:              state_next = S_IDLE;
                    endcase
                end
            end
            S_PULSE_A:
            begin
                cmd.pulse_a = 1'b1;
                state_next  = stat.phase_end ? S_PULSE_B : S_IDLE;
            end
            S_PULSE_B:
            begin
                cmd.pulse_b = 1'b1;
                state_next  = S_IDLE;
            end
            S_BYTE_CHK:
            begin
                cnt_next   = '0;
                state_next = stat.ge8 ? S_BYTE_POP : S_FIN;
            end
            S_BYTE_POP:
            begin
                cmd.pop_byte = 1'b1;
                cnt_next     = cnt_reg + 3'd1;
                if (cnt_reg == 3'(ptrdr_pkg::BYTE_BITS - 1))
                begin
                    cmd.set_ok = 1'b1;
                    state_next = S_FIN;
                end
            end
            S_ROLL:
            begin
                // one queued bit per cycle until a value lands or the queue runs dry
                if (stat.empty)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.roll_step = 1'b1;
                    if (stat.roll_hit)
                    begin
                        state_next = S_FIN;
                    end
                end
            end
            S_FIN:
            begin
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE);

endmodule

`default_nettype wire

FILE: design/ptrdr_dp.sv
// datapath: pulse interval compare, bit ring, byte shifter and dice roller
// depends on ptrdr_pkg; commanded by ptrdr_ctrl
`default_nettype none

module ptrdr_dp
#(
    parameter int QUEUE_BITS = 128
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire ptrdr_pkg::item_t    item,
    input  wire logic                cfg_we,
    input  wire logic [7:0]          cfg_data,
    input  wire ptrdr_pkg::cmd_t     cmd,
    output ptrdr_pkg::stat_t         stat,
    output logic                     result_valid,
    output ptrdr_pkg::result_t       result
);

    localparam int PTR_W = $clog2(QUEUE_BITS);
    localparam int HW    = (PTR_W > 7) ? PTR_W : 7;

    localparam logic [1:0] PHASE_START = 2'd0;
    localparam logic [1:0] PHASE_MID   = 2'd1;
    localparam logic [1:0] PHASE_END   = 2'd2;

    function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] q;
        q = (p == PTR_W'(QUEUE_BITS - 1)) ? '0 : p + PTR_W'(1);
        return q;
    endfunction

    logic                mem [QUEUE_BITS];
    logic                rd_reg;

    logic [PTR_W-1:0]    wp_reg, wp_next;
    logic [PTR_W-1:0]    rp_reg, rp_next;
    logic [1:0]          phase_reg, phase_next;
    logic [31:0]         older_reg, older_next;
    logic [31:0]         newer_reg, newer_next;
    logic                flip_reg, flip_next;
    logic [7:0]          span_reg, span_next;
    logic [7:0]          acc_reg, acc_next;
    logic [7:0]          range_reg, range_next;
    logic                valid_reg;

    logic [31:0]         time_reg;
    logic [31:0]         first_reg;
    logic [31:0]         second_reg;
    logic [7:0]          val_reg;
    logic                status_reg;
    ptrdr_pkg::result_t  res_reg;

    logic [HW:0]         held_wide;
    logic [HW-1:0]       held;
    logic                full;
    logic                empty;
    logic                push_en;
    logic                push_bit;
    logic [7:0]          span2;
    logic [7:0]          acc2;
    logic                span_ge;
    logic                roll_hit;
    logic [7:0]          cfg_clamped;

    // queue fill level, pointers may wrap at a non power of two depth
    always_comb
    begin
        held_wide = (HW+1)'(wp_reg) - (HW+1)'(rp_reg)
                  + ((wp_reg < rp_reg) ? (HW+1)'(QUEUE_BITS) : '0);
        held  = held_wide[HW-1:0];
        full  = (held == HW'(QUEUE_BITS - 1));
        empty = (wp_reg == rp_reg);
    end

    // roller step on the bit at the head of the ring
    always_comb
    begin
        span2    = {span_reg[6:0], 1'b0};
        acc2     = {acc_reg[6:0], rd_reg};
        span_ge  = (span2 >= range_reg);
        roll_hit = span_ge && (acc2 < range_reg);
    end

    always_comb
    begin
        priority if (cfg_data < ptrdr_pkg::DICE_MIN)
            cfg_clamped = ptrdr_pkg::DICE_MIN;
        else if (cfg_data > ptrdr_pkg::DICE_MAX)
            cfg_clamped = ptrdr_pkg::DICE_MAX;
        else
            cfg_clamped = cfg_data;
    end

    assign push_bit = flip_reg ? (first_reg > second_reg) : (first_reg < second_reg);
    assign push_en  = cmd.pulse_b && (first_reg != second_reg) && !full;

    always_comb
    begin
        wp_next    = wp_reg;
        rp_next    = rp_reg;
        phase_next = phase_reg;
        older_next = older_reg;
        newer_next = newer_reg;
        flip_next  = flip_reg;
        span_next  = span_reg;
        acc_next   = acc_reg;
        range_next = range_reg;

        if (cfg_we)
        begin
            range_next = cfg_clamped;
            span_next  = 8'd1;
            acc_next   = '0;
        end

        if (cmd.pulse_a)
        begin
            priority if (phase_reg == PHASE_MID)
            begin
                newer_next = time_reg;
                phase_next = PHASE_END;
            end
            else if (phase_reg == PHASE_END)
            begin
                phase_next = PHASE_END;
            end
            else
            begin
                older_next = time_reg;
                phase_next = PHASE_MID;
            end
        end

        if (cmd.pulse_b)
        begin
            if (first_reg != second_reg)
            begin
                flip_next = ~flip_reg;
            end
            if (push_en)
            begin
                wp_next = advance(wp_reg);
            end
            older_next = time_reg;
            phase_next = PHASE_MID;
        end

        if (cmd.pop_byte)
        begin
            rp_next = advance(rp_reg);
        end

        if (cmd.roll_step)
        begin
            rp_next = advance(rp_reg);
            priority if (roll_hit)
            begin
                span_next = 8'd1;
                acc_next  = '0;
            end
            else if (span_ge)
            begin
                span_next = span2 - range_reg;
                acc_next  = acc2 - range_reg;
            end
            else
            begin
                span_next = span2;
                acc_next  = acc2;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg    <= '0;
            rp_reg    <= '0;
            phase_reg <= PHASE_START;
            older_reg <= '0;
            newer_reg <= '0;
            flip_reg  <= 1'b0;
            span_reg  <= 8'd1;
            acc_reg   <= '0;
            range_reg <= ptrdr_pkg::DICE_RESET;
            valid_reg <= 1'b0;
        end
        else
        begin
            wp_reg    <= wp_next;
            rp_reg    <= rp_next;
            phase_reg <= phase_next;
            older_reg <= older_next;
            newer_reg <= newer_next;
            flip_reg  <= flip_next;
            span_reg  <= span_next;
            acc_reg   <= acc_next;
            range_reg <= range_next;
            valid_reg <= cmd.finish;
        end
    end

    // bit ring: one write port, read data registered at the next head pointer
    always_ff @(posedge clk)
    begin
        if (push_en)
        begin
            mem[wp_reg] <= push_bit;
        end
        rd_reg <= mem[rp_next];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            time_reg   <= item.pulse_time;
            val_reg    <= '0;
            status_reg <= ptrdr_pkg::STATUS_EMPTY;
        end
        if (cmd.pulse_a)
        begin
            first_reg  <= newer_reg - older_reg;
            second_reg <= time_reg - newer_reg;
        end
        if (cmd.pop_byte)
        begin
            val_reg <= {val_reg[6:0], rd_reg};
        end
        if (cmd.set_ok)
        begin
            status_reg <= ptrdr_pkg::STATUS_OK;
        end
        if (cmd.roll_step && roll_hit)
        begin
            val_reg    <= acc2;
            status_reg <= ptrdr_pkg::STATUS_OK;
        end
        if (cmd.finish)
        begin
            res_reg.value          <= val_reg;
            res_reg.status         <= status_reg;
            res_reg.bits_available <= held[6:0];
        end
    end

    assign stat.phase_end = (phase_reg == PHASE_END);
    assign stat.empty     = empty;
    assign stat.ge8       = (held >= HW'(ptrdr_pkg::BYTE_BITS));
    assign stat.roll_hit  = roll_hit;

    assign result_valid = valid_reg;
    assign result       = res_reg;

`ifndef NO_ASSERTIONS
    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        (wp_reg < PTR_W'(QUEUE_BITS - 1) || wp_reg == PTR_W'(QUEUE_BITS - 1))
        && (rp_reg < PTR_W'(QUEUE_BITS - 1) || rp_reg == PTR_W'(QUEUE_BITS - 1)))
        else $error("ring pointer beyond depth");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.pop_byte || cmd.roll_step) |-> !empty)
        else $error("pop from empty ring");

    a_roller_inv: assert property (@(posedge clk) disable iff (!rst_n)
        (acc_reg < span_reg) && (span_reg < range_reg || span_reg == 8'd1))
        else $error("roller accumulator out of span");

    a_strobe_once: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |=> !valid_reg)
        else $error("result strobe longer than one cycle");
`endif

endmodule

`default_nettype wire

FILE: design/pulse_timing_rng_dice_roller_core.sv
// Random bit source fed by pulse timestamps, with byte and dice-roll read-out.
// A pulse item passes S_PULSE_A, and also S_PULSE_B on the pulse that closes an interval pair;
// a byte request passes S_BYTE_CHK, pops 8 bits in S_BYTE_POP when at least 8 are queued, then
// S_FIN; a roll request consumes queued bits in S_ROLL until a value lands or the queue runs dry,
// then S_FIN. Both read-outs take bits through the bit ring's single read port, which yields one
// bit per cycle. Each result shows on result for exactly one cycle with result_valid high and
// must be taken then: the receiver cannot stall the block. A new item is taken whenever busy is
// low; dice_range is written through cfg_valid/cfg_ready.
// Depends on ptrdr_pkg, ptrdr_ctrl and ptrdr_dp.
`default_nettype none

module pulse_timing_rng_dice_roller_core
#(
    parameter int QUEUE_BITS = 128
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire ptrdr_pkg::item_t    item,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [7:0]          cfg_data,
    output logic                     result_valid,
    output ptrdr_pkg::result_t       result
);

    ptrdr_pkg::cmd_t  cmd;
    ptrdr_pkg::stat_t stat;
    logic             cfg_we;

    assign cfg_we = cfg_valid && cfg_ready;

    ptrdr_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .req_type  (item.req_type),
        .stat      (stat),
        .cmd       (cmd),
        .busy      (busy),
        .cfg_ready (cfg_ready)
    );

    ptrdr_dp #(
        .QUEUE_BITS (QUEUE_BITS)
    ) u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .cmd          (cmd),
        .stat         (stat),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

`default_nettype wire

FILE: tb/pulse_timing_rng_dice_roller_checker.sv
// checker for pulse_timing_rng_dice_roller_core: watches the item, config and result
// transfers, predicts each byte and roll result and compares them in order
// depends on ptrdr_pkg
module pulse_timing_rng_dice_roller_checker
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic                busy,
    input  wire ptrdr_pkg::item_t    item,
    input  wire logic                cfg_valid,
    input  wire logic                cfg_ready,
    input  wire logic [7:0]          cfg_data,
    input  wire logic                result_valid,
    input  wire ptrdr_pkg::result_t  result,
    output int                       outstanding,
    output int                       mismatches
);

    // predicted state of the random bit source
    logic       bit_store [128];
    logic [6:0] wr_idx;
    logic [6:0] rd_idx;
    logic [1:0] pulse_step;
    logic [31:0] t_start;
    logic [31:0] t_mid;
    logic       invert_cmp;
    logic [7:0] fdr_span;
    logic [7:0] fdr_draw;
    logic [7:0] outcomes;

    ptrdr_pkg::result_t due_draws [$];

    // pointers are 7 bits wide, so the difference wraps at the ring size
    function automatic logic [6:0] queued();
        return wr_idx - rd_idx;
    endfunction

    function automatic logic take_bit();
        logic b;
        b = bit_store[rd_idx];
        rd_idx = rd_idx + 7'd1;
        return b;
    endfunction

    function automatic void log_pulse(input logic [31:0] t);
        logic [31:0] first;
        logic [31:0] second;
        logic        b;
        if (pulse_step == 2'd1)
        begin
            t_mid = t;
            pulse_step = 2'd2;
        end
        else if (pulse_step == 2'd2)
        begin
            first = t_mid - t_start;
            second = t - t_mid;
            if (first != second)
            begin
                b = invert_cmp ? (first > second) : (first < second);
                invert_cmp = ~invert_cmp;
                // full ring drops the bit, the flip above still happens
                if (queued() != 7'd127)
                begin
                    bit_store[wr_idx] = b;
                    wr_idx = wr_idx + 7'd1;
                end
            end
            t_start = t;
            pulse_step = 2'd1;
        end
        else
        begin
            t_start = t;
            pulse_step = 2'd1;
        end
    endfunction

    function automatic void serve_request(input logic [1:0] req);
        ptrdr_pkg::result_t r;
        logic    b;
        logic    hit;
        r.value = '0;
        r.status = ptrdr_pkg::STATUS_EMPTY;
        hit = 1'b0;
        if (req == ptrdr_pkg::REQ_BYTE)
        begin
            if (queued() >= 7'd8)
            begin
                repeat (ptrdr_pkg::BYTE_BITS) r.value = {r.value[6:0], take_bit()};
                r.status = ptrdr_pkg::STATUS_OK;
            end
        end
        else
        begin
            // fast dice roller; a dry run keeps span and draw for the next roll
            while (queued() != 7'd0 && !hit)
            begin
                b = take_bit();
                fdr_span = fdr_span << 1;
                fdr_draw = {fdr_draw[6:0], b};
                if (fdr_span >= outcomes)
                begin
                    if (fdr_draw < outcomes)
                    begin
                        r.value = fdr_draw;
                        r.status = ptrdr_pkg::STATUS_OK;
                        fdr_span = 8'd1;
                        fdr_draw = 8'd0;
                        hit = 1'b1;
                    end
                    else
                    begin
                        fdr_span = fdr_span - outcomes;
                        fdr_draw = fdr_draw - outcomes;
                    end
                end
            end
        end
        r.bits_available = queued();
        due_draws.push_back(r);
    endfunction

    function automatic void compare_result(input ptrdr_pkg::result_t got);
        ptrdr_pkg::result_t want;
        if (due_draws.size() == 0)
        begin
            $display("%0t: result with none pending: expected nothing, %s %0d status %0d bits %0d",
                     $time, "got value", got.value, got.status, got.bits_available);
            mismatches++;
        end
        else
        begin
            want = due_draws.pop_front();
            if (got.value != want.value)
            begin
                $display("%0t: value expected %0d, got %0d", $time, want.value, got.value);
                mismatches++;
            end
            if (got.status != want.status)
            begin
                $display("%0t: status expected %0d, got %0d", $time, want.status, got.status);
                mismatches++;
            end
            if (got.bits_available != want.bits_available)
            begin
                $display("%0t: bits_available expected %0d, got %0d",
                         $time, want.bits_available, got.bits_available);
                mismatches++;
            end
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_idx = '0;
            rd_idx = '0;
            pulse_step = 2'd0;
            t_start = '0;
            t_mid = '0;
            invert_cmp = 1'b0;
            fdr_span = 8'd1;
            fdr_draw = 8'd0;
            outcomes = ptrdr_pkg::DICE_RESET;
            due_draws.delete();
            mismatches = 0;
            outstanding <= 0;
        end
        else
        begin
            // a result at this edge belongs to an item accepted earlier
            if (result_valid)
                compare_result(result);
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_data < ptrdr_pkg::DICE_MIN)
                    outcomes = ptrdr_pkg::DICE_MIN;
                else if (cfg_data > ptrdr_pkg::DICE_MAX)
                    outcomes = ptrdr_pkg::DICE_MAX;
                else
                    outcomes = cfg_data;
                fdr_span = 8'd1;
                fdr_draw = 8'd0;
            end
            if (start && !busy)
            begin
                case (item.req_type)
                    ptrdr_pkg::REQ_PULSE: log_pulse(item.pulse_time);
                    ptrdr_pkg::REQ_BYTE, ptrdr_pkg::REQ_ROLL: serve_request(item.req_type);
                    default: ;
                endcase
            end
            outstanding <= due_draws.size();
        end
    end

endmodule

FILE: tb/pulse_timing_rng_dice_roller_core_tb.sv
// testbench top for pulse_timing_rng_dice_roller_core: drives pulses, byte and roll
// requests and dice_range writes in random bursts; checking is done by
// pulse_timing_rng_dice_roller_checker; depends on ptrdr_pkg
module pulse_timing_rng_dice_roller_core_tb;

    localparam int WATCHDOG_LIMIT = 2000;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    ptrdr_pkg::item_t    item = '0;
    logic                cfg_valid = 1'b0;
    logic [7:0]          cfg_data = 8'd0;
    logic                busy;
    logic                cfg_ready;
    logic                result_valid;
    ptrdr_pkg::result_t  result;
    int                  outstanding;
    int                  mismatches;

    int          idle_cycles = 0;
    int          burst_left;
    logic [31:0] last_time;
    logic [7:0]  ranges [9];
    int          pulse_weight;

    always #2 clk = ~clk;

    pulse_timing_rng_dice_roller_core i_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .result       (result)
    );

    pulse_timing_rng_dice_roller_checker i_check
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .result       (result),
        .outstanding  (outstanding),
        .mismatches   (mismatches)
    );

    // ends the run when nothing has been transferred for too long
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_valid || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("pulse_timing_rng_dice_roller_core_tb NOT OK");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // one item transfer, then the burst/gap pacing of the sender
    task automatic issue(input logic [1:0] req, input logic [31:0] t);
        int gap;
        start <= 1'b1;
        item <= {req, t};
        do @(posedge clk); while (busy);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(0, 12);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // pulses mostly follow on from the last one; short steps give equal intervals
    task automatic next_pulse();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick == 0)
            last_time = $urandom();
        else if (pick < 6)
            last_time = last_time + $urandom_range(1, 4);
        else if (pick < 15)
            last_time = last_time + $urandom_range(1, 5000);
        else
            last_time = last_time + $urandom();
        issue(ptrdr_pkg::REQ_PULSE, last_time);
    endtask

    task automatic random_request();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 4)
            issue(ptrdr_pkg::REQ_BYTE, $urandom());
        else if (pick < 9)
            issue(ptrdr_pkg::REQ_ROLL, $urandom());
        else
            issue(ptrdr_pkg::REQ_NONE, $urandom());
    endtask

    task automatic drain();
        start <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    task automatic write_range(input logic [7:0] v);
        drain();
        // a pulse may still be in progress after the last result
        repeat (8) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        burst_left = 0;
        last_time = '0;
        ranges = '{8'd0, 8'd255, 8'd128, 8'd1, 8'd6, 8'd129, 8'd3, 8'd2, 8'd0};
        ranges[8] = 8'($urandom_range(4, 127));

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty ring, unused code, then hand-picked pulse timestamps
        issue(ptrdr_pkg::REQ_ROLL, 32'h0000_0000);
        issue(ptrdr_pkg::REQ_BYTE, 32'hFFFF_FFFF);
        issue(ptrdr_pkg::REQ_NONE, 32'hFFFF_FFFF);
        issue(ptrdr_pkg::REQ_PULSE, 32'h0000_0000);
        issue(ptrdr_pkg::REQ_PULSE, 32'hFFFF_FFFF);
        issue(ptrdr_pkg::REQ_PULSE, 32'hFFFF_FFFF);
        // wrapped interval equal to the next one: no bit
        issue(ptrdr_pkg::REQ_PULSE, 32'h0000_0009);
        issue(ptrdr_pkg::REQ_PULSE, 32'h0000_0013);
        issue(ptrdr_pkg::REQ_PULSE, 32'h0000_0014);
        issue(ptrdr_pkg::REQ_PULSE, 32'h8000_0000);
        issue(ptrdr_pkg::REQ_PULSE, 32'h8000_0001);
        issue(ptrdr_pkg::REQ_PULSE, 32'h8000_0009);
        // fewer than 8 bits queued
        issue(ptrdr_pkg::REQ_BYTE, 32'h0000_0000);
        issue(ptrdr_pkg::REQ_ROLL, 32'hFFFF_FFFF);
        issue(ptrdr_pkg::REQ_NONE, 32'h0000_0000);
        last_time = 32'h8000_0009;
        repeat (9) next_pulse();
        issue(ptrdr_pkg::REQ_BYTE, $urandom());
        issue(ptrdr_pkg::REQ_ROLL, $urandom());

        for (int p = 0; p < 9; p++)
        begin
            write_range(ranges[p]);
            if (p == 2)
            begin
                // overfill the ring so bits get dropped, then read it back out
                repeat (280) next_pulse();
                repeat (40) random_request();
            end
            else
            begin
                pulse_weight = $urandom_range(60, 90);
                repeat (130)
                begin
                    if ($urandom_range(0, 79) == 0)
                        drain();
                    if ($urandom_range(0, 99) < pulse_weight)
                        next_pulse();
                    else
                        random_request();
                end
            end
        end

        drain();
        repeat (20) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("pulse_timing_rng_dice_roller_core_tb OK");
        else
            $display("pulse_timing_rng_dice_roller_core_tb NOT OK");
        $finish;
    end

endmodule
